### rtl/core/contiguous_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// Contiguous fit allocator assertion macros
// Shared property forms for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define CFA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define CFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### rtl/core/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous fit allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int MEM_UNITS_DEFAULT    = 1024;
   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam int OWNER_BITS_DEFAULT   = 8;

   localparam int OWNER_ID_WIDTH     = 8;
   localparam int REQUEST_SIZE_WIDTH = 11;
   localparam int ADDRESS_WIDTH      = 10;
   localparam int STATUS_WIDTH       = 2;
   localparam int FIT_MODE_WIDTH     = 2;

   localparam logic [FIT_MODE_WIDTH-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_WIDTH-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_WIDTH-1:0] FIT_WORST = 2'd2;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_FREE     = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NO_OWNER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WRITE1,
      ST_SHIFT,
      ST_WRITE2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic scan;
      logic decide;
      logic write1;
      logic shift;
      logic write2;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic shift_done;
   } dp_status_type;

endpackage

### rtl/core/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous fit allocator
// First, best or worst fit allocator over an ordered table of segments.
//
//   channel  | handshake          | payload
//   req_     | req_valid/ready    | operation, owner_id, request_size
//   rsp_     | rsp_valid/ready    | status, address
//   csr_     | csr_valid/ready    | fit_mode
//
// One transaction at a time: the accept cycle, a scan of N table entries on
// the table's single read port, decide, a first write, a shift of M moved
// entries, a second write and the response.
// After reset the INIT state writes the initial segment before req_ready rises.
// A waiting response holds in the output register; the next transaction is
// accepted meanwhile and stalls only at its own response.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
   parameter int MEM_UNITS    = cfa_pkg::MEM_UNITS_DEFAULT,
   parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int OWNER_BITS   = cfa_pkg::OWNER_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_operation,
   input  logic [cfa_pkg::OWNER_ID_WIDTH-1:0]     req_owner_id,
   input  logic [cfa_pkg::REQUEST_SIZE_WIDTH-1:0] req_request_size,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cfa_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [cfa_pkg::ADDRESS_WIDTH-1:0]      rsp_address,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cfa_pkg::FIT_MODE_WIDTH-1:0]     csr_fit_mode
);

   cfa_pkg::ctrl_cmd_type  cmd;
   cfa_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cfa_datapath #(
      .MEM_UNITS    (MEM_UNITS),
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .OWNER_BITS   (OWNER_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_owner_id     (req_owner_id),
      .req_request_size (req_request_size),
      .csr_valid        (csr_valid),
      .csr_fit_mode     (csr_fit_mode),
      .rsp_status       (rsp_status),
      .rsp_address      (rsp_address)
   );

endmodule

### rtl/core/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// Contiguous fit allocator controller
// Sequences init, scan, decide, table update and response for one transaction.
// ----------------------------------------------------------------------------
module cfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cfa_pkg::ctrl_cmd_type  cmd,
   input  cfa_pkg::dp_status_type stat
);

   cfa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfa_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cfa_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = cfa_pkg::ST_IDLE;
         end
         cfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cfa_pkg::ST_SCAN;
            end
         end
         cfa_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = cfa_pkg::ST_DECIDE;
            end
         end
         cfa_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = cfa_pkg::ST_WRITE1;
         end
         cfa_pkg::ST_WRITE1: begin
            cmd.write1 = 1'b1;
            state_in   = cfa_pkg::ST_SHIFT;
         end
         cfa_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = cfa_pkg::ST_WRITE2;
            end
         end
         cfa_pkg::ST_WRITE2: begin
            cmd.write2 = 1'b1;
            state_in   = cfa_pkg::ST_DONE;
         end
         cfa_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.respond = 1'b1;
               state_in    = cfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfa_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/cfa_datapath.sv
// ----------------------------------------------------------------------------
// Contiguous fit allocator datapath
// Segment table memory, scan evaluation, update planning and entry shifter.
// ----------------------------------------------------------------------------
module cfa_datapath #(
   parameter int MEM_UNITS    = cfa_pkg::MEM_UNITS_DEFAULT,
   parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int OWNER_BITS   = cfa_pkg::OWNER_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cfa_pkg::ctrl_cmd_type                    cmd,
   output cfa_pkg::dp_status_type                   stat,
   input  logic                                     req_operation,
   input  logic [cfa_pkg::OWNER_ID_WIDTH-1:0]       req_owner_id,
   input  logic [cfa_pkg::REQUEST_SIZE_WIDTH-1:0]   req_request_size,
   input  logic                                     csr_valid,
   input  logic [cfa_pkg::FIT_MODE_WIDTH-1:0]       csr_fit_mode,
   output logic [cfa_pkg::STATUS_WIDTH-1:0]         rsp_status,
   output logic [cfa_pkg::ADDRESS_WIDTH-1:0]        rsp_address
);

   localparam int AW = $clog2(MEM_UNITS);
   localparam int LW = $clog2(MEM_UNITS + 1);
   localparam int CW = (LW > cfa_pkg::REQUEST_SIZE_WIDTH) ? LW : cfa_pkg::REQUEST_SIZE_WIDTH;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam int OB = OWNER_BITS;
   localparam int WW = AW + LW + OB + 1;
   localparam logic [NW-1:0] MAX_COUNT = NW'(MAX_SEGMENTS);
   localparam logic [LW-1:0] FULL_LEN  = LW'(MEM_UNITS);

   function automatic logic [WW-1:0] pack_word(logic [AW-1:0] s, logic [LW-1:0] l,
                                               logic [OB-1:0] o, logic f);
      return {s, l, o, f};
   endfunction

   // table memory: one write port, one registered read port
   logic [WW-1:0] mem [MAX_SEGMENTS];
   logic [IW-1:0] rd_addr;
   logic [WW-1:0] rd_data_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   logic [AW-1:0] e_start;
   logic [LW-1:0] e_len;
   logic [OB-1:0] e_owner;
   logic          e_free;

   assign e_start = rd_data_ff[WW-1 -: AW];
   assign e_len   = rd_data_ff[OB+LW -: LW];
   assign e_owner = rd_data_ff[OB:1];
   assign e_free  = rd_data_ff[0];

   // control registers
   logic [cfa_pkg::FIT_MODE_WIDTH-1:0] fit_mode_ff, fit_mode_in;
   logic [NW-1:0] count_ff, count_in;
   logic          eval_valid_ff, eval_valid_in;
   logic          pw_valid_ff, pw_valid_in;
   logic [NW-1:0] sh_left_ff, sh_left_in;

   // payload registers
   logic          op_ff, op_in;
   logic [OB-1:0] key_ff, key_in;
   logic [CW-1:0] size_ff, size_in;
   logic [NW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [IW-1:0] eval_idx_ff, eval_idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [LW-1:0] best_ff, best_in;
   logic [AW-1:0] pick_start_ff, pick_start_in;
   logic          last_free_ff, last_free_in;
   logic [LW-1:0] last_len_ff, last_len_in;
   logic [AW-1:0] last_start_ff, last_start_in;
   logic          prev_free_ff, prev_free_in;
   logic [LW-1:0] prev_len_ff, prev_len_in;
   logic [AW-1:0] prev_start_ff, prev_start_in;
   logic          need_next_ff, need_next_in;
   logic          next_free_ff, next_free_in;
   logic [LW-1:0] next_len_ff, next_len_in;
   cfa_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic          w1_en_ff, w1_en_in;
   logic [IW-1:0] w1_addr_ff, w1_addr_in;
   logic [WW-1:0] w1_data_ff, w1_data_in;
   logic          w2_en_ff, w2_en_in;
   logic [IW-1:0] w2_addr_ff, w2_addr_in;
   logic [WW-1:0] w2_data_ff, w2_data_in;
   logic [IW-1:0] sh_src_ff, sh_src_in;
   logic          sh_up_ff, sh_up_in;
   logic [1:0]    sh_gap_ff, sh_gap_in;
   logic [IW-1:0] pw_addr_ff, pw_addr_in;
   logic [cfa_pkg::STATUS_WIDTH-1:0]  rsp_status_ff, rsp_status_in;
   logic [cfa_pkg::ADDRESS_WIDTH-1:0] rsp_address_ff, rsp_address_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= cfa_pkg::FIT_FIRST;
         count_ff      <= NW'(1);
         eval_valid_ff <= 1'b0;
         pw_valid_ff   <= 1'b0;
         sh_left_ff    <= '0;
      end else begin
         fit_mode_ff   <= fit_mode_in;
         count_ff      <= count_in;
         eval_valid_ff <= eval_valid_in;
         pw_valid_ff   <= pw_valid_in;
         sh_left_ff    <= sh_left_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      size_ff        <= size_in;
      scan_ptr_ff    <= scan_ptr_in;
      eval_idx_ff    <= eval_idx_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      pick_start_ff  <= pick_start_in;
      last_free_ff   <= last_free_in;
      last_len_ff    <= last_len_in;
      last_start_ff  <= last_start_in;
      prev_free_ff   <= prev_free_in;
      prev_len_ff    <= prev_len_in;
      prev_start_ff  <= prev_start_in;
      need_next_ff   <= need_next_in;
      next_free_ff   <= next_free_in;
      next_len_ff    <= next_len_in;
      res_status_ff  <= res_status_in;
      res_addr_ff    <= res_addr_in;
      w1_en_ff       <= w1_en_in;
      w1_addr_ff     <= w1_addr_in;
      w1_data_ff     <= w1_data_in;
      w2_en_ff       <= w2_en_in;
      w2_addr_ff     <= w2_addr_in;
      w2_data_ff     <= w2_data_in;
      sh_src_ff      <= sh_src_in;
      sh_up_ff       <= sh_up_in;
      sh_gap_ff      <= sh_gap_in;
      pw_addr_ff     <= pw_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
   end

   // configuration and request capture
   always_comb begin
      fit_mode_in = csr_valid ? csr_fit_mode : fit_mode_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      size_in     = size_ff;
      if (cmd.load) begin
         op_in   = req_operation;
         key_in  = OB'({16'b0, req_owner_id});
         size_in = CW'(req_request_size);
      end
   end

   // scan: issue one read a cycle, evaluate the entry read the cycle before
   logic          issue;
   logic          fits;
   logic          better;
   logic          take_alloc;
   logic          take_free;

   assign issue = cmd.scan && (scan_ptr_ff < count_ff);

   always_comb begin
      fits   = e_free && (size_ff != '0) && (CW'(e_len) >= size_ff);
      better = !found_ff
               || ((fit_mode_ff == cfa_pkg::FIT_BEST) && (e_len < best_ff))
               || ((fit_mode_ff == cfa_pkg::FIT_WORST) && (e_len > best_ff));
      take_alloc = eval_valid_ff && (op_ff == cfa_pkg::OP_ALLOCATE) && fits && better;
      take_free  = eval_valid_ff && (op_ff == cfa_pkg::OP_FREE) && !found_ff && !e_free
                   && (e_owner == key_ff);

      scan_ptr_in   = scan_ptr_ff;
      eval_valid_in = issue;
      eval_idx_in   = IW'(scan_ptr_ff);
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      pick_start_in = pick_start_ff;
      last_free_in  = last_free_ff;
      last_len_in   = last_len_ff;
      last_start_in = last_start_ff;
      prev_free_in  = prev_free_ff;
      prev_len_in   = prev_len_ff;
      prev_start_in = prev_start_ff;
      need_next_in  = need_next_ff;
      next_free_in  = next_free_ff;
      next_len_in   = next_len_ff;

      if (cmd.load) begin
         scan_ptr_in  = '0;
         found_in     = 1'b0;
         need_next_in = 1'b0;
         next_free_in = 1'b0;
         last_free_in = 1'b0;
      end else begin
         if (issue) begin
            scan_ptr_in = scan_ptr_ff + NW'(1);
         end
         if (eval_valid_ff) begin
            if (take_alloc || take_free) begin
               found_in      = 1'b1;
               pick_in       = eval_idx_ff;
               best_in       = e_len;
               pick_start_in = e_start;
            end
            if (take_free) begin
               prev_free_in  = last_free_ff;
               prev_len_in   = last_len_ff;
               prev_start_in = last_start_ff;
               need_next_in  = 1'b1;
            end else if (need_next_ff) begin
               next_free_in = e_free;
               next_len_in  = e_len;
               need_next_in = 1'b0;
            end
            last_free_in  = e_free;
            last_len_in   = e_len;
            last_start_in = e_start;
         end
      end
   end

   assign stat.scan_done = (scan_ptr_ff >= count_ff) && !eval_valid_ff;

   // decide: plan the writes and the shift
   logic [CW-1:0] remain_wide;
   logic [LW-1:0] remain;
   logic [NW-1:0] pick_n;
   logic [NW-1:0] pick_p1;
   logic [LW-1:0] sum_next;
   logic [NW-1:0] drop_base;

   always_comb begin
      remain_wide = CW'(best_ff) - size_ff;
      remain      = LW'(remain_wide);
      pick_n      = NW'(pick_ff);
      pick_p1     = pick_n + NW'(1);
      sum_next    = best_ff + (next_free_ff ? next_len_ff : LW'(0));
      drop_base   = prev_free_ff ? pick_n : pick_p1;

      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      w1_en_in      = w1_en_ff;
      w1_addr_in    = w1_addr_ff;
      w1_data_in    = w1_data_ff;
      w2_en_in      = w2_en_ff;
      w2_addr_in    = w2_addr_ff;
      w2_data_in    = w2_data_ff;
      sh_up_in      = sh_up_ff;
      sh_gap_in     = sh_gap_ff;
      count_in      = count_ff;

      if (cmd.decide) begin
         res_status_in = cfa_pkg::STATUS_OK;
         res_addr_in   = pick_start_ff;
         w1_en_in      = 1'b0;
         w1_addr_in    = pick_ff;
         w1_data_in    = '0;
         w2_en_in      = 1'b0;
         w2_addr_in    = IW'(pick_p1);
         w2_data_in    = '0;
         sh_up_in      = 1'b0;
         sh_gap_in     = 2'd1;
         if (op_ff == cfa_pkg::OP_ALLOCATE) begin
            if (!found_ff) begin
               res_status_in = cfa_pkg::STATUS_NO_FIT;
               res_addr_in   = '0;
            end else if ((remain != '0) && (count_ff == MAX_COUNT)) begin
               res_status_in = cfa_pkg::STATUS_FULL;
               res_addr_in   = '0;
            end else begin
               w1_en_in   = 1'b1;
               w1_data_in = pack_word(pick_start_ff, LW'(size_ff), key_ff, 1'b0);
               if (remain != '0) begin
                  w2_en_in   = 1'b1;
                  w2_data_in = pack_word(AW'(CW'(pick_start_ff) + size_ff), remain,
                                         OB'(0), 1'b1);
                  sh_up_in   = 1'b1;
                  count_in   = count_ff + NW'(1);
               end
            end
         end else begin
            if (!found_ff) begin
               res_status_in = cfa_pkg::STATUS_NO_OWNER;
               res_addr_in   = '0;
            end else begin
               w1_en_in = 1'b1;
               if (prev_free_ff) begin
                  w1_addr_in = pick_ff - IW'(1);
                  w1_data_in = pack_word(prev_start_ff, prev_len_ff + sum_next, OB'(0), 1'b1);
               end else begin
                  w1_data_in = pack_word(pick_start_ff, sum_next, OB'(0), 1'b1);
               end
               if (prev_free_ff && next_free_ff) begin
                  sh_gap_in = 2'd2;
                  count_in  = count_ff - NW'(2);
               end else if (prev_free_ff || next_free_ff) begin
                  count_in  = count_ff - NW'(1);
               end
            end
         end
      end
   end

   // shifter: read one entry a cycle, write it at its new place the next cycle
   logic sh_step;

   assign sh_step = cmd.shift && (sh_left_ff != '0);

   always_comb begin
      sh_src_in   = sh_src_ff;
      sh_left_in  = sh_left_ff;
      pw_valid_in = 1'b0;
      pw_addr_in  = pw_addr_ff;
      if (cmd.decide) begin
         sh_left_in = '0;
         if ((op_ff == cfa_pkg::OP_ALLOCATE) && found_ff && (remain != '0)
             && (count_ff != MAX_COUNT)) begin
            sh_src_in  = IW'(count_ff - NW'(1));
            sh_left_in = count_ff - pick_p1;
         end else if ((op_ff == cfa_pkg::OP_FREE) && found_ff
                      && (prev_free_ff || next_free_ff)) begin
            if (prev_free_ff && next_free_ff) begin
               sh_src_in  = IW'(drop_base + NW'(2));
               sh_left_in = count_ff - drop_base - NW'(2);
            end else begin
               sh_src_in  = IW'(drop_base + NW'(1));
               sh_left_in = count_ff - drop_base - NW'(1);
            end
         end
      end else if (sh_step) begin
         sh_left_in  = sh_left_ff - NW'(1);
         pw_valid_in = 1'b1;
         if (sh_up_ff) begin
            sh_src_in  = sh_src_ff - IW'(1);
            pw_addr_in = sh_src_ff + IW'(1);
         end else begin
            sh_src_in  = sh_src_ff + IW'(1);
            pw_addr_in = sh_src_ff - IW'(sh_gap_ff);
         end
      end
   end

   assign stat.shift_done = (sh_left_ff == '0) && !pw_valid_ff;

   assign rd_addr = cmd.shift ? sh_src_ff : IW'(scan_ptr_ff);

   // single write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.init) begin
         wr_en   = 1'b1;
         wr_data = pack_word(AW'(0), FULL_LEN, OB'(0), 1'b1);
      end else if (pw_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = pw_addr_ff;
         wr_data = rd_data_ff;
      end else if (cmd.write1 && w1_en_ff) begin
         wr_en   = 1'b1;
         wr_addr = w1_addr_ff;
         wr_data = w1_data_ff;
      end else if (cmd.write2 && w2_en_ff) begin
         wr_en   = 1'b1;
         wr_addr = w2_addr_ff;
         wr_data = w2_data_ff;
      end
   end

   // response register
   always_comb begin
      rsp_status_in  = rsp_status_ff;
      rsp_address_in = rsp_address_ff;
      if (cmd.respond) begin
         rsp_status_in  = res_status_ff;
         rsp_address_in = cfa_pkg::ADDRESS_WIDTH'({{cfa_pkg::ADDRESS_WIDTH{1'b0}}, res_addr_ff});
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

### rtl/core/cfa_checker.sv
// ----------------------------------------------------------------------------
// Contiguous fit allocator checker
// Port-level checks on request and response behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "contiguous_fit_allocator_defines.svh"

module cfa_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [cfa_pkg::STATUS_WIDTH-1:0]       rsp_status,
   input logic [cfa_pkg::ADDRESS_WIDTH-1:0]      rsp_address
);

   `CFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_address))
   `CFA_ASSERT_SAME(a_fail_zero_addr, clock, reset, rsp_valid && (rsp_status != cfa_pkg::STATUS_OK), rsp_address == '0)
   `CFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CFA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_address (rsp_address)
);
